/* hdl/assert_macros.svh */
// Assertion macros shared by the frame receiver RTL.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SLCFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SLCFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/slcfr_pkg.sv */
// Shared types and constants for the framed serial receiver.
// Used by slcfr_ctrl, slcfr_dp and the top level.
package slcfr_pkg;

    localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'h0D;

    // Controller phases
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_CSUM,
        ST_END,
        ST_RD,
        ST_LOAD
    } state_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic byte_start;   // incoming word is the start byte
        logic byte_end;     // incoming word is the end byte
        logic len_small;    // length word is 0 or 1
        logic len_big;      // length word exceeds the buffer depth plus one
        logic data_done;    // this data word is the final payload word
        logic sum_ok;       // checksum word matches running sum
        logic frame_empty;  // stored frame has no payload
        logic rd_last;      // read pointer is at the final payload word
        logic out_free;     // output register can take a result
    } slcfr_stat_t;

    // Controller commands toward the datapath
    typedef struct packed {
        logic hunt_clr;     // start byte seen: clear frame counters
        logic ld_id;        // capture message id
        logic ld_len;       // capture length word
        logic wr_data;      // store a payload word
        logic rd_init;      // point reader at payload word 0
        logic rd_next;      // advance reader
        logic ld_out;       // load output register
    } slcfr_cmd_t;

endpackage

/* hdl/slcfr_ctrl.sv */
// Frame receiver controller: phase state machine and input flow control.
// Depends on slcfr_pkg.
module slcfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  slcfr_pkg::slcfr_stat_t stat,
    output slcfr_pkg::slcfr_cmd_t  cmd
);
    import slcfr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   acc;
    logic   done;

    // Input is held off while a frame is read out
    assign in_stall = (state_reg == ST_RD) || (state_reg == ST_LOAD);
    assign acc      = in_valid && !in_stall;
    assign done     = stat.frame_empty || stat.rd_last;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (acc && stat.byte_start)
                begin
                    state_next = ST_ID;
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    if (stat.len_small)
                    begin
                        state_next = ST_CSUM;
                    end
                    else if (stat.len_big)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (acc && stat.data_done)
                begin
                    state_next = ST_CSUM;
                end
            end
            ST_CSUM:
            begin
                if (acc)
                begin
                    state_next = stat.sum_ok ? ST_END : ST_HUNT;
                end
            end
            ST_END:
            begin
                if (acc)
                begin
                    state_next = stat.byte_end ? ST_RD : ST_HUNT;
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = done ? ST_HUNT : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_HUNT:
            begin
                cmd.hunt_clr = acc && stat.byte_start;
            end
            ST_ID:
            begin
                cmd.ld_id = acc;
            end
            ST_LEN:
            begin
                cmd.ld_len = acc;
            end
            ST_DATA:
            begin
                cmd.wr_data = acc;
            end
            ST_END:
            begin
                cmd.rd_init = acc && stat.byte_end;
            end
            ST_LOAD:
            begin
                cmd.ld_out  = stat.out_free;
                cmd.rd_next = stat.out_free && !done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/slcfr_dp.sv */
// Frame receiver datapath: header capture, checksum, payload buffer,
// readout pointer and output register. Depends on slcfr_pkg.
module slcfr_dp #(
    parameter int unsigned PAYLOAD_DEPTH = slcfr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             rx_byte,
    input  logic                   out_stall,
    input  slcfr_pkg::slcfr_cmd_t  cmd,
    output slcfr_pkg::slcfr_stat_t stat,
    output logic                   out_valid,
    output logic [7:0]             msg_id,
    output logic                   has_payload,
    output logic [7:0]             payload_byte,
    output logic [5:0]             byte_index,
    output logic [6:0]             payload_count,
    output logic                   last
);
    import slcfr_pkg::*;

    localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);

    logic [7:0]    mem [PAYLOAD_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [7:0]    id_reg,     id_next;
    logic [7:0]    remain_reg, remain_next;
    logic [CW-1:0] wpos_reg,   wpos_next;
    logic [7:0]    sum_reg,    sum_next;
    logic [AW-1:0] rptr_reg,   rptr_next;

    logic          ovalid_reg,  ovalid_next;
    logic [7:0]    oid_reg,     oid_next;
    logic          ohas_reg,    ohas_next;
    logic [7:0]    obyte_reg,   obyte_next;
    logic [5:0]    oidx_reg,    oidx_next;
    logic [6:0]    ocount_reg,  ocount_next;
    logic          olast_reg,   olast_next;

    // Status decode
    always_comb
    begin
        stat.byte_start  = (rx_byte == START_BYTE);
        stat.byte_end    = (rx_byte == END_BYTE);
        stat.len_small   = (rx_byte <= 8'd1);
        stat.len_big     = ({1'b0, rx_byte} > 9'(PAYLOAD_DEPTH + 1));
        stat.data_done   = (remain_reg == 8'd1);
        stat.sum_ok      = (sum_reg == rx_byte);
        stat.frame_empty = (wpos_reg == '0);
        stat.rd_last     = ((8'(rptr_reg) + 8'd1) == 8'(wpos_reg));
        stat.out_free    = !ovalid_reg || !out_stall;
    end

    // Frame counters and header fields
    always_comb
    begin
        id_next     = id_reg;
        remain_next = remain_reg;
        wpos_next   = wpos_reg;
        sum_next    = sum_reg;
        rptr_next   = rptr_reg;
        if (cmd.hunt_clr)
        begin
            wpos_next = '0;
            sum_next  = '0;
        end
        if (cmd.ld_id)
        begin
            id_next = rx_byte;
        end
        if (cmd.ld_len)
        begin
            sum_next    = rx_byte;
            wpos_next   = '0;
            remain_next = (stat.len_small || stat.len_big) ? 8'd0 : rx_byte - 8'd1;
        end
        if (cmd.wr_data)
        begin
            wpos_next   = wpos_reg + 1'b1;
            sum_next    = sum_reg + rx_byte;
            remain_next = remain_reg - 8'd1;
        end
        if (cmd.rd_init)
        begin
            rptr_next = '0;
        end
        if (cmd.rd_next)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
    end

    // Output register: loaded by the controller, cleared when taken
    always_comb
    begin
        ovalid_next = ovalid_reg;
        oid_next    = oid_reg;
        ohas_next   = ohas_reg;
        obyte_next  = obyte_reg;
        oidx_next   = oidx_reg;
        ocount_next = ocount_reg;
        olast_next  = olast_reg;
        if (cmd.ld_out)
        begin
            ovalid_next = 1'b1;
            oid_next    = id_reg;
            ohas_next   = !stat.frame_empty;
            obyte_next  = stat.frame_empty ? 8'd0 : rd_data_reg;
            oidx_next   = stat.frame_empty ? 6'd0 : 6'(rptr_reg);
            ocount_next = 7'(wpos_reg);
            olast_next  = stat.frame_empty || stat.rd_last;
        end
        else if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            wpos_reg   <= '0;
            sum_reg    <= '0;
            rptr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            remain_reg <= remain_next;
            wpos_reg   <= wpos_next;
            sum_reg    <= sum_next;
            rptr_reg   <= rptr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        oid_reg    <= oid_next;
        ohas_reg   <= ohas_next;
        obyte_reg  <= obyte_next;
        oidx_reg   <= oidx_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
    end

    // Payload buffer write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_data)
        begin
            mem[wpos_reg[AW-1:0]] <= rx_byte;
        end
    end

    // Payload buffer read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rptr_reg];
    end

    assign out_valid     = ovalid_reg;
    assign msg_id        = oid_reg;
    assign has_payload   = ohas_reg;
    assign payload_byte  = obyte_reg;
    assign byte_index    = oidx_reg;
    assign payload_count = ocount_reg;
    assign last          = olast_reg;

endmodule

/* hdl/sof_len_checksum_frame_receiver_core.sv */
// Framed serial receiver (start, id, length, payload, sum8 checksum, end).
// Throughput: one input word per cycle while a frame is received.
// Readout: after the end byte each result word takes a buffer read, then an output load
// that waits for a free output register; input is stalled during readout.
// Reset: rst_n asynchronous, active low; returns to hunting, output empty.
// Depends on slcfr_pkg, slcfr_ctrl, slcfr_dp and assert_macros.svh.
`include "assert_macros.svh"

module sof_len_checksum_frame_receiver_core #(
    parameter int unsigned PAYLOAD_DEPTH = slcfr_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] msg_id,
    output logic       has_payload,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic [6:0] payload_count,
    output logic       last
);
    import slcfr_pkg::*;

    slcfr_cmd_t  cmd;
    slcfr_stat_t stat;

    // Phase controller
    slcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Buffer, checksum and output register
    slcfr_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .msg_id        (msg_id),
        .has_payload   (has_payload),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .payload_count (payload_count),
        .last          (last)
    );

    // Checks
    `SLCFR_ASSERT_SAME(a_load_stalls_input, clk, rst_n, cmd.ld_out, in_stall, "result load while input open")
    `SLCFR_ASSERT_SAME(a_index_in_range, clk, rst_n, out_valid && has_payload, ({1'b0, byte_index} < payload_count), "byte index beyond payload count")
    `SLCFR_ASSERT_SAME(a_empty_is_last, clk, rst_n, out_valid && !has_payload, (last && (payload_count == 7'd0)), "empty frame result malformed")
    `SLCFR_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, cmd.ld_out, out_valid, "loaded result not presented")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sof_len_checksum_frame_receiver_core.
// Depends on slcfr_pkg and the core RTL; a built-in frame predictor checks every result word.
module tb;
    import slcfr_pkg::*;

    localparam int unsigned DEPTH       = PAYLOAD_DEPTH_DEF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 40;

    // one result word of an accepted frame
    typedef struct packed {
        logic [7:0] id;
        logic       has;
        logic [7:0] data;
        logic [5:0] idx;
        logic [6:0] cnt;
        logic       fin;
    } frame_word_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_END,
        FR_OVERSIZE,
        FR_NOISE,
        FR_CUT
    } frame_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] msg_id;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [6:0] payload_count;
    logic       last;

    // stimulus and expectations
    logic [7:0]  stim_q[$];
    frame_word_t exp_words[$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        long_hold = 1'b0;
    bit          hold_req = 1'b0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          frames_ok = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;

    // predictor state
    state_t      rx_phase = ST_HUNT;
    logic [7:0]  cur_id = 8'h00;
    logic [7:0]  left_cnt = 8'h00;
    logic [6:0]  wr_pos = 7'd0;
    logic [7:0]  sum_acc = 8'h00;
    logic [7:0]  pay_buf [DEPTH];

    // directed words: empty frames of length zero and one, bad checksum,
    // bad end word, oversized length
    logic [7:0] dir_seq [24] = '{
        START_BYTE, 8'h00, 8'h00, 8'h00, END_BYTE,
        START_BYTE, 8'hFF, 8'h01, 8'h01, END_BYTE,
        START_BYTE, 8'h11, 8'h02, 8'h44, 8'h00, END_BYTE,
        START_BYTE, 8'h22, 8'h00, 8'h00, 8'h0C,
        START_BYTE, 8'h33, 8'hFF
    };

    sof_len_checksum_frame_receiver_core #(
        .PAYLOAD_DEPTH(DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .msg_id       (msg_id),
        .has_payload  (has_payload),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .payload_count(payload_count),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // push the result words of a completed frame
    function automatic void emit_frame();
        frame_word_t w;
        frames_ok++;
        if (wr_pos == 0)
        begin
            w = '{id: cur_id, has: 1'b0, data: 8'h00, idx: 6'd0, cnt: 7'd0, fin: 1'b1};
            exp_words.push_back(w);
        end
        else
        begin
            for (int k = 0; k < wr_pos; k++)
            begin
                w.id   = cur_id;
                w.has  = 1'b1;
                w.data = pay_buf[k];
                w.idx  = k[5:0];
                w.cnt  = wr_pos;
                w.fin  = (k + 1 == wr_pos);
                exp_words.push_back(w);
            end
        end
    endfunction

    // advance the frame parser by one received word
    function automatic void predict_word(input logic [7:0] b);
        case (rx_phase)
            ST_HUNT:
            begin
                if (b == START_BYTE)
                begin
                    rx_phase = ST_ID;
                    wr_pos   = 7'd0;
                    sum_acc  = 8'h00;
                end
            end
            ST_ID:
            begin
                cur_id   = b;
                rx_phase = ST_LEN;
            end
            ST_LEN:
            begin
                sum_acc = b;
                wr_pos  = 7'd0;
                if (b <= 8'd1)
                begin
                    left_cnt = 8'd0;
                    rx_phase = ST_CSUM;
                end
                else if (int'(b) - 1 > int'(DEPTH))
                begin
                    left_cnt = 8'd0;
                    rx_phase = ST_HUNT;
                end
                else
                begin
                    left_cnt = b - 8'd1;
                    rx_phase = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (wr_pos < DEPTH)
                begin
                    pay_buf[wr_pos] = b;
                    wr_pos = wr_pos + 7'd1;
                end
                sum_acc = sum_acc + b;
                if (left_cnt > 0)
                    left_cnt = left_cnt - 8'd1;
                if (left_cnt == 0)
                    rx_phase = ST_CSUM;
            end
            ST_CSUM:
                rx_phase = (sum_acc == b) ? ST_END : ST_HUNT;
            ST_END:
            begin
                if (b == END_BYTE)
                    emit_frame();
                rx_phase = ST_HUNT;
            end
            default:
                rx_phase = ST_HUNT;
        endcase
    endfunction

    // sender: offers queued words, idles at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_word(rx_byte);
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (stim_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= stim_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each accepted result word, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t got;
        frame_word_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{id: msg_id, has: has_payload, data: payload_byte, idx: byte_index,
                        cnt: payload_count, fin: last};
                if (exp_words.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result word id=%h has=%b data=%h idx=%0d cnt=%0d last=%b",
                             $time, got.id, got.has, got.data, got.idx, got.cnt, got.fin);
                end
                else
                begin
                    want = exp_words.pop_front();
                    n_checked++;
                    if (got !== want)
                    begin
                        mismatch_cnt++;
                        $display("%0t: expected id=%h has=%b data=%h idx=%0d cnt=%0d last=%b",
                                 $time, want.id, want.has, want.data, want.idx, want.cnt,
                                 want.fin);
                        $display("%0t: actual   id=%h has=%b data=%h idx=%0d cnt=%0d last=%b",
                                 $time, got.id, got.has, got.data, got.idx, got.cnt, got.fin);
                    end
                end
            end
            out_stall <= long_hold || ($urandom_range(99) < sink_stall_pct);
        end
    end

    // long receiver hold-off once results are waiting
    initial
    begin
        wait (hold_req);
        while (exp_words.size() == 0)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic put(input logic [7:0] b);
        stim_q.push_back(b);
        n_queued++;
    endtask

    // one frame of the given kind; length word as given
    task automatic queue_frame(input frame_kind_t kind, input logic [7:0] len);
        logic [7:0] csum;
        logic [7:0] pay;
        int         n;
        put(START_BYTE);
        put(8'($urandom_range(255)));
        put(len);
        if (kind == FR_OVERSIZE)
        begin
            repeat ($urandom_range(3)) put(8'($urandom_range(255)));
            return;
        end
        csum = len;
        n = (len > 8'd1) ? int'(len) - 1 : 0;
        if (kind == FR_CUT)
            n = (n == 0) ? 0 : int'($urandom_range(n - 1));
        for (int i = 0; i < n; i++)
        begin
            pay = 8'($urandom_range(255));
            put(pay);
            csum = csum + pay;
        end
        if (kind == FR_CUT)
            return;
        if (kind == FR_BAD_SUM)
            csum = csum ^ (8'h01 << $urandom_range(7));
        put(csum);
        if (kind == FR_BAD_END)
            put(END_BYTE ^ (8'h01 << $urandom_range(7)));
        else
            put(END_BYTE);
    endtask

    // mostly short payloads, a few up to the buffer size
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'($urandom_range(1));
        else if (r < 80)
            return 8'($urandom_range(9, 2));
        else if (r < 95)
            return 8'($urandom_range(DEPTH + 1, 10));
        else
            return 8'(DEPTH + 1);
    endfunction

    task automatic queue_random(input int target);
        int start;
        int r;
        start = n_queued;
        while (n_queued - start < target)
        begin
            r = $urandom_range(99);
            if (r < 70)
                queue_frame(FR_GOOD, pick_len());
            else if (r < 78)
                queue_frame(FR_BAD_SUM, pick_len());
            else if (r < 85)
                queue_frame(FR_BAD_END, pick_len());
            else if (r < 90)
                queue_frame(FR_OVERSIZE, 8'($urandom_range(255, DEPTH + 2)));
            else if (r < 95)
                repeat ($urandom_range(6, 1)) put(8'($urandom_range(255)));
            else
                queue_frame(FR_CUT, pick_len());
        end
    endtask

    // everything sent and every expected word received
    task automatic wait_drained();
        do
            @(negedge clk);
        while (stim_q.size() != 0 || in_valid || exp_words.size() != 0);
    endtask

    // reset, then directed words followed by random phases
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_seq[i])
            put(dir_seq[i]);
        wait_drained();

        queue_random(35);
        wait_drained();

        src_idle_pct <= 59;
        queue_random(25);
        wait_drained();

        src_idle_pct   <= 0;
        sink_stall_pct <= 59;
        queue_random(25);
        wait_drained();

        src_idle_pct   <= 25;
        sink_stall_pct <= 25;
        queue_random(25);
        wait_drained();

        // back-pressure: full-size frame, then the receiver holds off
        src_idle_pct   <= 0;
        sink_stall_pct <= 0;
        queue_frame(FR_GOOD, 8'(DEPTH + 1));
        queue_frame(FR_OVERSIZE, 8'(DEPTH + 2));
        hold_req = 1'b1;
        queue_random(15);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d input words, %0d good frames, %0d result words checked",
                 n_accepted, frames_ok, n_checked);
        $display("Idle phases: none, sender, receiver, both, plus a long receiver hold-off");
        if (mismatch_cnt == 0 && exp_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
